// ===== design/matrix_to_trs_quaternion_top_macros.svh =====
// Assertion macros used by the matrix to TRS quaternion RTL.
// Depends on nothing; each user supplies clk and rst_n in its own scope.
`ifndef MATRIX_TO_TRS_QUATERNION_TOP_MACROS_SVH
`define MATRIX_TO_TRS_QUATERNION_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mtq_pkg.sv =====
// Shared types, latencies and helpers for the matrix to TRS quaternion block.
// Depends on nothing.
package mtq_pkg;

    localparam int SQRT_LAT  = 32;
    localparam int DIV_LAT   = 33;
    localparam int FRONT_PRE = 2;
    localparam int BACK_LAT  = 1 + SQRT_LAT + DIV_LAT + 1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} mtq_branch_t;

    typedef struct packed {
        logic signed [31:0] col0_x;
        logic signed [31:0] col0_y;
        logic signed [31:0] col0_z;
        logic signed [31:0] col1_x;
        logic signed [31:0] col1_y;
        logic signed [31:0] col1_z;
        logic signed [31:0] col2_x;
        logic signed [31:0] col2_y;
        logic signed [31:0] col2_z;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
    } mtq_in_t;

    typedef struct packed {
        logic signed [31:0] out_move_x;
        logic signed [31:0] out_move_y;
        logic signed [31:0] out_move_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] rot_w;
        logic [31:0]        scale_x;
        logic [31:0]        scale_y;
        logic [31:0]        scale_z;
    } mtq_out_t;

    typedef struct packed {
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
        logic [31:0]        scale_x;
        logic [31:0]        scale_y;
        logic [31:0]        scale_z;
    } mtq_side_t;

    function automatic logic signed [31:0] mtq_neg_sat(input logic signed [31:0] v);
        return (v == S32_MIN) ? S32_MAX : -v;
    endfunction

endpackage

// ===== design/matrix_to_trs_quaternion_top.sv =====
// Top level of the affine matrix to translation, quaternion and scale block.
// Depends on mtq_pkg, mtq_front and mtq_back.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+--------------------------------------
//  input    | start, busy, matrix    | item taken when start and not busy
//  result   | done, result           | one-cycle strobe, cannot be held off
//
// An item may enter every cycle; busy is always low.
// Each result passes through the normalising half (square roots and
// dividers, one bit per stage) and then the quaternion half. Reset clears
// every valid bit; items in flight are lost.
module matrix_to_trs_quaternion_top
    import mtq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  mtq_in_t  matrix,
    output logic     done,
    output mtq_out_t result
);

    logic               f_valid;
    logic signed [31:0] f_nrm [9];
    mtq_side_t          f_side;

    assign busy = 1'b0;

    mtq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .mat       (matrix),
        .out_valid (f_valid),
        .nrm       (f_nrm),
        .side      (f_side)
    );

    mtq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .nrm       (f_nrm),
        .side      (f_side),
        .out_valid (done),
        .result    (result)
    );

endmodule

// ===== design/mtq_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on mtq_pkg for the stage count.
module mtq_isqrt
    import mtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] radicand,
    output logic        out_valid,
    output logic [31:0] root
);

    logic        v_reg   [SQRT_LAT];
    logic [32:0] rem_reg [SQRT_LAT];
    logic [31:0] rt_reg  [SQRT_LAT];
    logic [63:0] rad_reg [SQRT_LAT];

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
        logic        p_v;
        logic [32:0] p_rem;
        logic [31:0] p_rt;
        logic [63:0] p_rad;
        logic [34:0] cur;
        logic [34:0] trial;
        logic        ge;
        logic [32:0] rem_next;
        logic [31:0] rt_next;

        if (k == 0) begin : g_first
            assign p_v   = in_valid;
            assign p_rem = '0;
            assign p_rt  = '0;
            assign p_rad = radicand;
        end
        else begin : g_rest
            assign p_v   = v_reg[k-1];
            assign p_rem = rem_reg[k-1];
            assign p_rt  = rt_reg[k-1];
            assign p_rad = rad_reg[k-1];
        end

        always_comb
        begin
            cur      = {p_rem, p_rad[63:62]};
            trial    = {1'b0, p_rt, 2'b01};
            ge       = (cur >= trial);
            rem_next = ge ? 33'(cur - trial) : cur[32:0];
            rt_next  = {p_rt[30:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= p_v;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            rt_reg[k]  <= rt_next;
            rad_reg[k] <= {p_rad[61:0], 2'b00};
        end
    end

    assign out_valid = v_reg[SQRT_LAT-1];
    assign root      = rt_reg[SQRT_LAT-1];

endmodule

// ===== design/mtq_div.sv =====
// Pipelined signed divider: num * 2^30 / den, truncated, saturated to 32 bits.
// Depends on mtq_pkg for limits; a zero divisor gives zero.
module mtq_div
    import mtq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [32:0] num,
    input  logic [32:0]        den,
    output logic               out_valid,
    output logic signed [31:0] quo
);

    localparam int QSTAGES = DIV_LAT - 1;

    logic [32:0] mag;
    logic [62:0] numer;
    logic        s0_v_reg;
    logic [32:0] s0_r_reg;
    logic [31:0] s0_lo_reg;
    logic [32:0] d_reg;
    logic        neg_reg;
    logic        ovf_reg;
    logic        zero_reg;

    logic        v_reg  [QSTAGES];
    logic [32:0] r_reg  [QSTAGES];
    logic [31:0] lo_reg [QSTAGES];
    logic [31:0] q_reg  [QSTAGES];
    logic [32:0] d_dly_reg [QSTAGES-1];

    always_comb
    begin
        mag   = num[32] ? 33'(-num) : 33'(num);
        numer = {mag, 30'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_r_reg  <= {2'b00, numer[62:32]};
        s0_lo_reg <= numer[31:0];
        d_reg     <= den;
        neg_reg   <= num[32];
        ovf_reg   <= ({2'b00, numer[62:32]} >= den);
        zero_reg  <= (den == '0);
    end

    for (genvar k = 0; k < QSTAGES; k++) begin : g_stage
        logic        p_v;
        logic [32:0] p_r;
        logic [31:0] p_lo;
        logic [31:0] p_q;
        logic [32:0] p_d;
        logic [33:0] cur;
        logic        ge;

        if (k == 0) begin : g_first
            assign p_v  = s0_v_reg;
            assign p_r  = s0_r_reg;
            assign p_lo = s0_lo_reg;
            assign p_q  = '0;
            assign p_d  = d_reg;
        end
        else begin : g_rest
            assign p_v  = v_reg[k-1];
            assign p_r  = r_reg[k-1];
            assign p_lo = lo_reg[k-1];
            assign p_q  = q_reg[k-1];
            assign p_d  = d_dly_reg[k-1];
        end

        always_comb
        begin
            cur = {p_r, p_lo[31]};
            ge  = (cur >= {1'b0, p_d});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= p_v;
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[k]  <= ge ? 33'(cur - {1'b0, p_d}) : cur[32:0];
            lo_reg[k] <= {p_lo[30:0], 1'b0};
            q_reg[k]  <= {p_q[30:0], ge};
        end
    end

    // The sign, overflow and zero flags sit in the first stage; hold them to the end.
    logic [QSTAGES-1:0] neg_dly_reg;
    logic [QSTAGES-1:0] ovf_dly_reg;
    logic [QSTAGES-1:0] zero_dly_reg;

    always_ff @(posedge clk)
    begin
        neg_dly_reg  <= {neg_dly_reg[QSTAGES-2:0], neg_reg};
        ovf_dly_reg  <= {ovf_dly_reg[QSTAGES-2:0], ovf_reg};
        zero_dly_reg <= {zero_dly_reg[QSTAGES-2:0], zero_reg};
    end

    assign out_valid = v_reg[QSTAGES-1];

    logic [31:0] qm;
    logic        fneg;
    logic        fovf;
    logic        fzero;

    always_comb
    begin
        qm    = q_reg[QSTAGES-1];
        fneg  = neg_dly_reg[QSTAGES-1];
        fovf  = ovf_dly_reg[QSTAGES-1];
        fzero = zero_dly_reg[QSTAGES-1];
        if (fzero)
        begin
            quo = '0;
        end
        else if (!fneg)
        begin
            quo = (fovf || qm[31]) ? S32_MAX : $signed(qm);
        end
        else
        begin
            quo = (fovf || (qm[31] && (qm[30:0] != '0))) ? S32_MIN : $signed(32'(0 - qm));
        end
    end

    // The divisor register must follow its item through the bit stages.
    for (genvar k = 0; k < QSTAGES-1; k++) begin : g_dchk
        if (k == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                d_dly_reg[k] <= d_reg;
            end
        end
        else begin : g_rest
            always_ff @(posedge clk)
            begin
                d_dly_reg[k] <= d_dly_reg[k-1];
            end
        end
    end

endmodule

// ===== design/mtq_front.sv =====
// Column lengths and normalisation: squares, sums, square roots, dividers.
// Depends on mtq_pkg, mtq_isqrt and mtq_div.
module mtq_front
    import mtq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  mtq_in_t            mat,
    output logic               out_valid,
    output logic signed [31:0] nrm [9],
    output mtq_side_t          side
);

    localparam int FD = FRONT_PRE + SQRT_LAT;

    logic signed [31:0] el [9];
    logic [31:0]        mag [9];
    logic [63:0]        sq_reg [9];
    logic [63:0]        sum_reg [3];
    logic               v1_reg;
    logic               v2_reg;
    mtq_in_t            in_dly_reg [FD];
    mtq_side_t          side_dly_reg [DIV_LAT];
    logic [2:0]         sq_v;
    logic [31:0]        len [3];
    logic [8:0]         dv_v;
    mtq_in_t            dm;
    logic signed [31:0] del [9];
    mtq_side_t          side_now;

    always_comb
    begin
        el[0] = mat.col0_x;
        el[1] = mat.col0_y;
        el[2] = mat.col0_z;
        el[3] = mat.col1_x;
        el[4] = mat.col1_y;
        el[5] = mat.col1_z;
        el[6] = mat.col2_x;
        el[7] = mat.col2_y;
        el[8] = mat.col2_z;
        for (int i = 0; i < 9; i++)
        begin
            mag[i] = el[i][31] ? 32'(-el[i]) : 32'(el[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            sq_reg[i] <= {32'b0, mag[i]} * {32'b0, mag[i]};
        end
        for (int j = 0; j < 3; j++)
        begin
            sum_reg[j] <= sq_reg[3*j] + sq_reg[3*j+1] + sq_reg[3*j+2];
        end
        in_dly_reg[0] <= mat;
        for (int k = 1; k < FD; k++)
        begin
            in_dly_reg[k] <= in_dly_reg[k-1];
        end
        side_dly_reg[0] <= side_now;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            side_dly_reg[k] <= side_dly_reg[k-1];
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_len
        mtq_isqrt u_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v2_reg),
            .radicand  (sum_reg[j]),
            .out_valid (sq_v[j]),
            .root      (len[j])
        );
    end

    always_comb
    begin
        dm     = in_dly_reg[FD-1];
        del[0] = dm.col0_x;
        del[1] = dm.col0_y;
        del[2] = dm.col0_z;
        del[3] = dm.col1_x;
        del[4] = dm.col1_y;
        del[5] = dm.col1_z;
        del[6] = dm.col2_x;
        del[7] = dm.col2_y;
        del[8] = dm.col2_z;
        side_now.move_x  = dm.move_x;
        side_now.move_y  = dm.move_y;
        side_now.move_z  = dm.move_z;
        side_now.scale_x = len[0];
        side_now.scale_y = len[1];
        side_now.scale_z = len[2];
    end

    for (genvar i = 0; i < 9; i++) begin : g_norm
        mtq_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (&sq_v),
            .num       (33'(del[i])),
            .den       ({1'b0, len[i/3]}),
            .out_valid (dv_v[i]),
            .quo       (nrm[i])
        );
    end

    assign out_valid = &dv_v;
    assign side      = side_dly_reg[DIV_LAT-1];

endmodule

// ===== design/mtq_back.sv =====
// Shepperd branch choice, square root of the radicand and quaternion division.
// Depends on mtq_pkg, mtq_isqrt, mtq_div and the assertion macro header.
`include "matrix_to_trs_quaternion_top_macros.svh"

module mtq_back
    import mtq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] nrm [9],
    input  mtq_side_t          side,
    output logic               out_valid,
    output mtq_out_t           result
);

    localparam logic signed [34:0] ONE_Q = 35'sd1073741824;

    typedef struct packed {
        mtq_branch_t        br;
        logic signed [32:0] nw;
        logic signed [32:0] nx;
        logic signed [32:0] ny;
        logic signed [32:0] nz;
        mtq_side_t          side;
    } mid_t;

    typedef struct packed {
        mtq_branch_t br;
        logic [31:0] half;
        mtq_side_t   side;
    } post_t;

    logic signed [34:0] e00, e11, e22, trace, rad;
    logic signed [32:0] na, nb, nc, nd, ne, nf;
    mtq_branch_t        br;
    mid_t               mid_now;
    logic [63:0]        radicand;

    logic               v1_reg;
    mid_t               s1_reg;
    logic [63:0]        radicand_reg;
    mid_t               mid_dly_reg [SQRT_LAT];
    post_t              post_dly_reg [DIV_LAT];

    logic               rt_v;
    logic [31:0]        root;
    mid_t               md;
    post_t              post_now;
    post_t              pd;
    logic [3:0]         dv_v;
    logic signed [31:0] dq [4];
    logic signed [31:0] half_s;
    logic signed [31:0] qw, qx, qy, qz;

    logic               done_reg;
    mtq_out_t           result_reg;
    mtq_branch_t        br_out_reg;

    always_comb
    begin
        e00   = 35'(nrm[0]);
        e11   = 35'(nrm[4]);
        e22   = 35'(nrm[8]);
        trace = e00 + e11 + e22;
        na    = 33'(nrm[5]) - 33'(nrm[7]);
        nb    = 33'(nrm[6]) - 33'(nrm[2]);
        nc    = 33'(nrm[1]) - 33'(nrm[3]);
        nd    = 33'(nrm[3]) + 33'(nrm[1]);
        ne    = 33'(nrm[6]) + 33'(nrm[2]);
        nf    = 33'(nrm[7]) + 33'(nrm[5]);
        if (trace > 0)
        begin
            br = BR_W;
        end
        else if ((e00 > e11) && (e00 > e22))
        begin
            br = BR_X;
        end
        else if (e11 > e22)
        begin
            br = BR_Y;
        end
        else
        begin
            br = BR_Z;
        end
        mid_now.br   = br;
        mid_now.side = side;
        case (br)
            BR_W:
            begin
                rad        = trace + ONE_Q;
                mid_now.nw = '0;
                mid_now.nx = na;
                mid_now.ny = nb;
                mid_now.nz = nc;
            end
            BR_X:
            begin
                rad        = ONE_Q + e00 - e11 - e22;
                mid_now.nw = na;
                mid_now.nx = '0;
                mid_now.ny = nd;
                mid_now.nz = ne;
            end
            BR_Y:
            begin
                rad        = ONE_Q + e11 - e00 - e22;
                mid_now.nw = nb;
                mid_now.nx = nd;
                mid_now.ny = '0;
                mid_now.nz = nf;
            end
            default:
            begin
                rad        = ONE_Q + e22 - e00 - e11;
                mid_now.nw = nc;
                mid_now.nx = ne;
                mid_now.ny = nf;
                mid_now.nz = '0;
            end
        endcase
        radicand = (rad > 0) ? 64'({rad[32:0], 30'b0}) : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            done_reg <= &dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg         <= mid_now;
        radicand_reg   <= radicand;
        mid_dly_reg[0] <= s1_reg;
        for (int k = 1; k < SQRT_LAT; k++)
        begin
            mid_dly_reg[k] <= mid_dly_reg[k-1];
        end
        post_dly_reg[0] <= post_now;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            post_dly_reg[k] <= post_dly_reg[k-1];
        end
    end

    mtq_isqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .radicand  (radicand_reg),
        .out_valid (rt_v),
        .root      (root)
    );

    always_comb
    begin
        md            = mid_dly_reg[SQRT_LAT-1];
        post_now.br   = md.br;
        post_now.half = {1'b0, root[31:1]};
        post_now.side = md.side;
    end

    mtq_div u_dw (
        .clk (clk), .rst_n (rst_n), .in_valid (rt_v), .num (md.nw),
        .den ({root, 1'b0}), .out_valid (dv_v[0]), .quo (dq[0])
    );
    mtq_div u_dx (
        .clk (clk), .rst_n (rst_n), .in_valid (rt_v), .num (md.nx),
        .den ({root, 1'b0}), .out_valid (dv_v[1]), .quo (dq[1])
    );
    mtq_div u_dy (
        .clk (clk), .rst_n (rst_n), .in_valid (rt_v), .num (md.ny),
        .den ({root, 1'b0}), .out_valid (dv_v[2]), .quo (dq[2])
    );
    mtq_div u_dz (
        .clk (clk), .rst_n (rst_n), .in_valid (rt_v), .num (md.nz),
        .den ({root, 1'b0}), .out_valid (dv_v[3]), .quo (dq[3])
    );

    always_comb
    begin
        pd     = post_dly_reg[DIV_LAT-1];
        half_s = $signed(pd.half);
        qw     = (pd.br == BR_W) ? half_s : dq[0];
        qx     = (pd.br == BR_X) ? half_s : dq[1];
        qy     = (pd.br == BR_Y) ? half_s : dq[2];
        qz     = (pd.br == BR_Z) ? half_s : dq[3];
    end

    always_ff @(posedge clk)
    begin
        result_reg.out_move_x <= pd.side.move_x;
        result_reg.out_move_y <= mtq_neg_sat(pd.side.move_y);
        result_reg.out_move_z <= pd.side.move_z;
        result_reg.rot_x      <= mtq_neg_sat(qx);
        result_reg.rot_y      <= qy;
        result_reg.rot_z      <= mtq_neg_sat(qz);
        result_reg.rot_w      <= qw;
        result_reg.scale_x    <= pd.side.scale_x;
        result_reg.scale_y    <= pd.side.scale_y;
        result_reg.scale_z    <= pd.side.scale_z;
        br_out_reg            <= pd.br;
    end

    assign out_valid = done_reg;
    assign result    = result_reg;

    `MTQ_ASSERT_NXT(a_back_latency, in_valid, ##(BACK_LAT-1) done_reg,
        "item did not leave the back pipeline on time")
    `MTQ_ASSERT_IMP(a_trace_w_pos, done_reg && (br_out_reg == BR_W),
        result_reg.rot_w > 32'sd0, "trace branch gave a non-positive w")
    `MTQ_ASSERT_IMP(a_diag_x_sign, done_reg && (br_out_reg == BR_X),
        result_reg.rot_x <= 32'sd0, "x branch gave a positive mirrored x")

endmodule

// ===== tb/matrix_to_trs_quaternion_top_tb.sv =====
// Testbench for matrix_to_trs_quaternion_top: directed and random affine matrices,
// checked field by field against a fixed-point Shepperd conversion computed here.
// Depends on mtq_pkg and the matrix_to_trs_quaternion_top RTL.
`timescale 1ns / 100ps

module matrix_to_trs_quaternion_top_tb;
    import mtq_pkg::*;

    localparam longint ONE_Q30 = 64'sd1 << 30;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    mtq_in_t  matrix;
    logic     done;
    mtq_out_t result;

    mtq_in_t  pending_items[$];
    mtq_out_t expected_trs[$];
    int       idle_pct;
    int       fail_count;
    longint   cycle_count;

    matrix_to_trs_quaternion_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .matrix(matrix), .done(done), .result(result)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fix_div(longint num, longint den);
        if (den == 0)
            return 0;
        return (num * ONE_Q30) / den;
    endfunction

    function automatic longint unsigned unit_column(inout longint c[3]);
        longint unsigned acc;
        longint unsigned len;
        longint unsigned m;
        acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            m = (c[i] < 0) ? -c[i] : c[i];
            acc = acc + m * m;
        end
        len = root64(acc);
        if (len > 0)
            for (int i = 0; i < 3; i++)
                c[i] = fix_div(c[i], longint'(len));
        return len;
    endfunction

    function automatic mtq_out_t matrix_to_trs(mtq_in_t m);
        longint a[3], b[3], c[3];
        longint unsigned sx, sy, sz;
        longint tr, rad, rt, s, qx, qy, qz, qw;
        mtq_out_t r;
        a = '{longint'(m.col0_x), longint'(m.col0_y), longint'(m.col0_z)};
        b = '{longint'(m.col1_x), longint'(m.col1_y), longint'(m.col1_z)};
        c = '{longint'(m.col2_x), longint'(m.col2_y), longint'(m.col2_z)};
        sx = unit_column(a);
        sy = unit_column(b);
        sz = unit_column(c);
        tr = a[0] + b[1] + c[2];
        if (tr > 0)
        begin
            rad = tr + ONE_Q30;
            rt = longint'(root64(longint'(rad) << 30));
            s = 2 * rt;
            qw = rt / 2;
            qx = fix_div(b[2] - c[1], s);
            qy = fix_div(c[0] - a[2], s);
            qz = fix_div(a[1] - b[0], s);
        end
        else if (a[0] > b[1] && a[0] > c[2])
        begin
            rad = ONE_Q30 + a[0] - b[1] - c[2];
            rt = rad > 0 ? longint'(root64(rad << 30)) : 0;
            s = 2 * rt;
            qw = fix_div(b[2] - c[1], s);
            qx = rt / 2;
            qy = fix_div(b[0] + a[1], s);
            qz = fix_div(c[0] + a[2], s);
        end
        else if (b[1] > c[2])
        begin
            rad = ONE_Q30 + b[1] - a[0] - c[2];
            rt = rad > 0 ? longint'(root64(rad << 30)) : 0;
            s = 2 * rt;
            qw = fix_div(c[0] - a[2], s);
            qx = fix_div(b[0] + a[1], s);
            qy = rt / 2;
            qz = fix_div(c[1] + b[2], s);
        end
        else
        begin
            rad = ONE_Q30 + c[2] - a[0] - b[1];
            rt = rad > 0 ? longint'(root64(rad << 30)) : 0;
            s = 2 * rt;
            qw = fix_div(a[1] - b[0], s);
            qx = fix_div(c[0] + a[2], s);
            qy = fix_div(c[1] + b[2], s);
            qz = rt / 2;
        end
        r.out_move_x = m.move_x;
        r.out_move_y = 32'(clamp32(-longint'(m.move_y)));
        r.out_move_z = m.move_z;
        r.rot_x = 32'(clamp32(-clamp32(qx)));
        r.rot_y = 32'(clamp32(qy));
        r.rot_z = 32'(clamp32(-clamp32(qz)));
        r.rot_w = 32'(clamp32(qw));
        r.scale_x = sx[31:0];
        r.scale_y = sy[31:0];
        r.scale_z = sz[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] rand_elem(int kind);
        case (kind)
            0: return $signed(32'($urandom_range(0, 131072))) - 32'sd65536;
            1: return $signed($urandom());
            2: return $signed(32'($urandom_range(0, 255))) - 32'sd128;
            default: return '0;
        endcase
    endfunction

    function automatic mtq_in_t rand_matrix();
        mtq_in_t m;
        int k;
        int sc;
        k = $urandom_range(0, 9);
        m.move_x = $signed($urandom());
        m.move_y = $signed($urandom());
        m.move_z = $signed($urandom());
        if (k < 6)
        begin
            // Scaled signed permutation matrix with a small perturbation.
            int p;
            sc = $urandom_range(1, 1 << 20);
            p = $urandom_range(0, 5);
            m.col0_x = 0; m.col0_y = 0; m.col0_z = 0;
            m.col1_x = 0; m.col1_y = 0; m.col1_z = 0;
            m.col2_x = 0; m.col2_y = 0; m.col2_z = 0;
            m.col0_x = rand_elem(2); m.col1_y = rand_elem(2); m.col2_z = rand_elem(2);
            case (p)
                0: begin m.col0_x = sc; m.col1_y = sc; m.col2_z = sc; end
                1: begin m.col0_x = -sc; m.col1_y = -sc; m.col2_z = sc; end
                2: begin m.col0_x = sc; m.col1_y = -sc; m.col2_z = -sc; end
                3: begin m.col0_x = -sc; m.col1_y = sc; m.col2_z = -sc; end
                4: begin m.col0_y = sc; m.col1_z = sc; m.col2_x = sc; end
                default: begin m.col0_z = -sc; m.col1_x = sc; m.col2_y = -sc; end
            endcase
            m.col0_y = m.col0_y + rand_elem(2);
            m.col1_z = m.col1_z + rand_elem(2);
            m.col2_x = m.col2_x + rand_elem(2);
        end
        else
        begin
            m.col0_x = rand_elem(k & 1); m.col0_y = rand_elem(k & 1);
            m.col0_z = rand_elem(k & 1); m.col1_x = rand_elem(k & 1);
            m.col1_y = rand_elem(k & 1); m.col1_z = rand_elem(k & 1);
            m.col2_x = rand_elem(k & 1); m.col2_y = rand_elem(k & 1);
            m.col2_z = rand_elem(k == 9 ? 3 : (k & 1));
        end
        return m;
    endfunction

    function automatic mtq_in_t diag_matrix(int a, int b, int c);
        mtq_in_t m;
        m = '0;
        m.col0_x = a;
        m.col1_y = b;
        m.col2_z = c;
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start  <= 1'b0;
            matrix <= '0;
        end
        else if (start && !busy)
        begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                matrix <= pending_items.pop_front();
            else
                start <= 1'b0;
        end
        else if (!start && pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct)
        begin
            start  <= 1'b1;
            matrix <= pending_items.pop_front();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            expected_trs.push_back(matrix_to_trs(matrix));
    end

    always @(posedge clk)
    begin
        mtq_out_t e;
        if (rst_n && done)
        begin
            if (expected_trs.size() == 0)
            begin
                $error("unexpected result item");
                fail_count++;
            end
            else
            begin
                e = expected_trs.pop_front();
                if (result.out_move_x !== e.out_move_x)
                begin
                    $error("out_move_x exp %h got %h", e.out_move_x, result.out_move_x);
                    fail_count++;
                end
                if (result.out_move_y !== e.out_move_y)
                begin
                    $error("out_move_y exp %h got %h", e.out_move_y, result.out_move_y);
                    fail_count++;
                end
                if (result.out_move_z !== e.out_move_z)
                begin
                    $error("out_move_z exp %h got %h", e.out_move_z, result.out_move_z);
                    fail_count++;
                end
                if (result.rot_x !== e.rot_x)
                begin
                    $error("rot_x exp %h got %h", e.rot_x, result.rot_x);
                    fail_count++;
                end
                if (result.rot_y !== e.rot_y)
                begin
                    $error("rot_y exp %h got %h", e.rot_y, result.rot_y);
                    fail_count++;
                end
                if (result.rot_z !== e.rot_z)
                begin
                    $error("rot_z exp %h got %h", e.rot_z, result.rot_z);
                    fail_count++;
                end
                if (result.rot_w !== e.rot_w)
                begin
                    $error("rot_w exp %h got %h", e.rot_w, result.rot_w);
                    fail_count++;
                end
                if (result.scale_x !== e.scale_x)
                begin
                    $error("scale_x exp %h got %h", e.scale_x, result.scale_x);
                    fail_count++;
                end
                if (result.scale_y !== e.scale_y)
                begin
                    $error("scale_y exp %h got %h", e.scale_y, result.scale_y);
                    fail_count++;
                end
                if (result.scale_z !== e.scale_z)
                begin
                    $error("scale_z exp %h got %h", e.scale_z, result.scale_z);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("matrix_to_trs_quaternion_top test failed");
            $finish;
        end
    end

    initial
    begin
        mtq_in_t m;
        int phase_pct[4];
        rst_n = 1'b0;
        idle_pct = 0;
        fail_count = 0;
        cycle_count = 0;
        phase_pct = '{0, 67, 0, 29};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: identity, each Shepperd branch, zero and extreme columns.
        pending_items.push_back(diag_matrix(65536, 65536, 65536));
        pending_items.push_back(diag_matrix(65536, -65536, -65536));
        pending_items.push_back(diag_matrix(-65536, 65536, -65536));
        pending_items.push_back(diag_matrix(-65536, -65536, 65536));
        pending_items.push_back(diag_matrix(0, 0, 0));
        pending_items.push_back(diag_matrix(0, 65536, 0));
        m = '0;
        m.col0_x = S32_MIN; m.col0_y = S32_MIN; m.col0_z = S32_MIN;
        m.col1_x = S32_MAX; m.col1_y = S32_MAX; m.col1_z = S32_MAX;
        m.col2_x = S32_MIN; m.col2_y = S32_MAX; m.col2_z = S32_MIN;
        m.move_x = S32_MIN; m.move_y = S32_MIN; m.move_z = S32_MAX;
        pending_items.push_back(m);
        m = '1;
        pending_items.push_back(m);
        m = '0;
        m.col0_y = 65536; m.col1_x = 65536; m.col2_z = 1;
        m.move_y = S32_MAX;
        pending_items.push_back(m);
        m = '0;
        m.col0_x = 1; m.col1_x = 1; m.col2_x = 1;
        pending_items.push_back(m);
        m = '0;
        m.col0_x = -1; m.col1_z = 5; m.col2_y = -7; m.move_y = 1;
        pending_items.push_back(m);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_pct[ph];
            for (int i = 0; i < 160; i++)
                pending_items.push_back(rand_matrix());
            while (pending_items.size() > 0)
                @(posedge clk);
        end
        @(posedge clk);
        while (expected_trs.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (fail_count == 0)
            $display("matrix_to_trs_quaternion_top test passed");
        else
            $display("matrix_to_trs_quaternion_top test failed");
        $finish;
    end

endmodule

// ===== matrix_to_trs_quaternion_top.f =====
+incdir+design
design/mtq_pkg.sv
design/mtq_isqrt.sv
design/mtq_div.sv
design/mtq_front.sv
design/mtq_back.sv
design/matrix_to_trs_quaternion_top.sv
tb/matrix_to_trs_quaternion_top_tb.sv
